// File: rtl/core/kms_pkg.sv
// Shared types, constants and the control program of the motion smoother.
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

  localparam int SUM_WIDTH_DEF = 48;
  localparam int MOT_W         = 32;
  localparam int VAR_W         = 32;
  localparam int VAR_FRAC      = 24;
  localparam int NOISE_W       = 28;
  localparam int K_W           = VAR_FRAC + 1;
  localparam int CHUNK_W       = 24;
  localparam int MUL_A_W       = 32;
  localparam int PROD_W        = MUL_A_W + K_W;
  localparam int CNT_W         = 5;
  localparam int DIV_STEPS     = K_W;
  localparam int STEP_W        = 5;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE    = 1'd1;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 28'd67109;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST    = 28'd4194304;

  localparam logic [K_W-1:0]   K_ONE   = 25'h100_0000;
  localparam logic [VAR_W-1:0] VAR_ONE = 32'h0100_0000;

  // jump targets in the program
  localparam logic [STEP_W-1:0] PC_DIV     = 5'd5;
  localparam logic [STEP_W-1:0] PC_MUL_X   = 5'd8;
  localparam logic [STEP_W-1:0] PC_MUL_Y   = 5'd12;
  localparam logic [STEP_W-1:0] PC_MUL_ROT = 5'd16;
  localparam logic [STEP_W-1:0] PC_INIT    = 5'd21;
  localparam logic [STEP_W-1:0] PC_OUT     = 5'd22;
  localparam logic [STEP_W-1:0] PC_START   = 5'd0;

  typedef enum logic [3:0] {
    OP_SUM,
    OP_PP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_K_SET,
    OP_MAG,
    OP_MUL_CHUNK,
    OP_ACC,
    OP_MOVE,
    OP_VAR_MUL,
    OP_VAR_SET,
    OP_INIT,
    OP_DIFF,
    OP_CORR,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_FIRST,
    BR_LOOP,
    BR_JUMP,
    BR_END
  } br_t;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_ROT
  } axis_t;

  typedef struct packed {
    op_t                op;
    axis_t              axis;
    br_t                br;
    logic [STEP_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic              en;
    op_t               op;
    axis_t             axis;
    logic [CNT_W-1:0]  cnt;
  } dp_ctl_t;

  // number of 24-bit pieces in the magnitude of a sum difference
  function automatic int nchunk(input int sum_w);
    return (sum_w + CHUNK_W) / CHUNK_W;
  endfunction

  function automatic uword_t mk(input op_t op, input axis_t axis, input br_t br,
                                input logic [STEP_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.axis   = axis;
    w.br     = br;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = mk(OP_SUM,       AX_X,   BR_NEXT,  PC_START);
      5'd1:    w = mk(OP_SUM,       AX_Y,   BR_NEXT,  PC_START);
      5'd2:    w = mk(OP_SUM,       AX_ROT, BR_FIRST, PC_INIT);
      5'd3:    w = mk(OP_PP,        AX_X,   BR_NEXT,  PC_START);
      5'd4:    w = mk(OP_DIV_INIT,  AX_X,   BR_NEXT,  PC_START);
      5'd5:    w = mk(OP_DIV_STEP,  AX_X,   BR_LOOP,  PC_DIV);
      5'd6:    w = mk(OP_K_SET,     AX_X,   BR_NEXT,  PC_START);
      5'd7:    w = mk(OP_MAG,       AX_X,   BR_NEXT,  PC_START);
      5'd8:    w = mk(OP_MUL_CHUNK, AX_X,   BR_NEXT,  PC_START);
      5'd9:    w = mk(OP_ACC,       AX_X,   BR_LOOP,  PC_MUL_X);
      5'd10:   w = mk(OP_MOVE,      AX_X,   BR_NEXT,  PC_START);
      5'd11:   w = mk(OP_MAG,       AX_Y,   BR_NEXT,  PC_START);
      5'd12:   w = mk(OP_MUL_CHUNK, AX_Y,   BR_NEXT,  PC_START);
      5'd13:   w = mk(OP_ACC,       AX_Y,   BR_LOOP,  PC_MUL_Y);
      5'd14:   w = mk(OP_MOVE,      AX_Y,   BR_NEXT,  PC_START);
      5'd15:   w = mk(OP_MAG,       AX_ROT, BR_NEXT,  PC_START);
      5'd16:   w = mk(OP_MUL_CHUNK, AX_ROT, BR_NEXT,  PC_START);
      5'd17:   w = mk(OP_ACC,       AX_ROT, BR_LOOP,  PC_MUL_ROT);
      5'd18:   w = mk(OP_MOVE,      AX_ROT, BR_NEXT,  PC_START);
      5'd19:   w = mk(OP_VAR_MUL,   AX_X,   BR_NEXT,  PC_START);
      5'd20:   w = mk(OP_VAR_SET,   AX_X,   BR_JUMP,  PC_OUT);
      5'd21:   w = mk(OP_INIT,      AX_X,   BR_NEXT,  PC_START);
      5'd22:   w = mk(OP_DIFF,      AX_X,   BR_NEXT,  PC_START);
      5'd23:   w = mk(OP_CORR,      AX_X,   BR_NEXT,  PC_START);
      5'd24:   w = mk(OP_DIFF,      AX_Y,   BR_NEXT,  PC_START);
      5'd25:   w = mk(OP_CORR,      AX_Y,   BR_NEXT,  PC_START);
      5'd26:   w = mk(OP_DIFF,      AX_ROT, BR_NEXT,  PC_START);
      5'd27:   w = mk(OP_CORR,      AX_ROT, BR_NEXT,  PC_START);
      5'd28:   w = mk(OP_DONE,      AX_X,   BR_END,   PC_START);
      default: w = mk(OP_DONE,      AX_X,   BR_END,   PC_START);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/kms_datapath.sv
// Datapath of the motion smoother: filter state, shared divider, multiplier and adders.
`timescale 1ns / 1ps
`default_nettype none
module kms_datapath #(
  parameter int SUM_WIDTH = kms_pkg::SUM_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  ld,
  input  wire logic signed [kms_pkg::MOT_W-1:0] in_shift_x,
  input  wire logic signed [kms_pkg::MOT_W-1:0] in_shift_y,
  input  wire logic signed [kms_pkg::MOT_W-1:0] in_rotation,
  input  wire                                  in_motion_valid,
  input  wire                                  in_restart,
  input  wire logic [kms_pkg::NOISE_W-1:0]     process_noise,
  input  wire logic [kms_pkg::NOISE_W-1:0]     measurement_noise,
  input  wire kms_pkg::dp_ctl_t                ctl,
  output logic                                 first_frame,
  output logic signed [kms_pkg::MOT_W-1:0]     res_x,
  output logic signed [kms_pkg::MOT_W-1:0]     res_y,
  output logic signed [kms_pkg::MOT_W-1:0]     res_rot
);
  import kms_pkg::*;

  localparam int SW      = SUM_WIDTH;
  localparam int MAG_W   = SW + 1;
  localparam int NCHUNK  = nchunk(SW);
  localparam int CIDX_W  = $clog2(NCHUNK);
  localparam int PAD_W   = NCHUNK * CHUNK_W;
  localparam int ACC_W   = PAD_W + K_W;
  localparam int COR_W   = 37;
  localparam int DIFF_W  = (MAG_W > COR_W - 1) ? MAG_W : COR_W - 1;

  localparam logic signed [SW-1:0]     SUM_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]     SUM_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [DIFF_W-1:0] D_LIM   = DIFF_W'(64'sd17179869184);
  localparam logic signed [COR_W-1:0]  V_MAX   = 37'sd2147483647;
  localparam logic signed [COR_W-1:0]  V_MIN   = -37'sd2147483648;
  localparam logic signed [MOT_W-1:0]  OUT_MAX = 32'sh7fff_ffff;
  localparam logic signed [MOT_W-1:0]  OUT_MIN = 32'sh8000_0000;

  // filter state
  logic                     first_r;
  logic signed [MOT_W-1:0]  held_r [3];
  logic signed [SW-1:0]     sum_r  [3];
  logic signed [SW-1:0]     est_r  [3];
  logic [VAR_W-1:0]         ev_r;

  // scratch registers
  logic [VAR_W-1:0]         pp_r;
  logic [VAR_W:0]           den_r;
  logic [VAR_W:0]           rem_r;
  logic [K_W-1:0]           shin_r;
  logic [K_W-1:0]           q_r;
  logic [K_W-1:0]           k_r;
  logic                     up_r;
  logic [MAG_W-1:0]         mag_r;
  logic [ACC_W-1:0]         acc_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [MOT_W-1:0]  res_r  [3];

  // combinational terms
  logic signed [MOT_W-1:0]  m_cur;
  logic signed [SW-1:0]     sum_cur;
  logic signed [SW-1:0]     est_cur;
  logic signed [MAG_W-1:0]  sum_add;
  logic signed [SW-1:0]     sum_sat;
  logic [VAR_W:0]           pp_sum;
  logic [VAR_W-1:0]         pp_sat;
  logic [VAR_W+1:0]         trial;
  logic [VAR_W+1:0]         trial_sub;
  logic                     trial_ge;
  logic signed [MAG_W-1:0]  d_mag;
  logic [MAG_W-1:0]         mag_val;
  logic [PAD_W-1:0]         mag_pad;
  logic [CHUNK_W-1:0]       chunk_arr [NCHUNK];
  logic [CHUNK_W-1:0]       chunk;
  logic [MUL_A_W-1:0]       mul_a;
  logic [K_W-1:0]           mul_b;
  logic [MAG_W-1:0]         step;
  logic [MAG_W-1:0]         move_val;
  logic signed [DIFF_W-1:0] d_out;
  logic signed [COR_W-1:0]  v_cor;
  logic signed [MOT_W-1:0]  v_sat;

  always_comb begin
    m_cur   = held_r[ctl.axis];
    sum_cur = sum_r[ctl.axis];
    est_cur = est_r[ctl.axis];

    // saturating trajectory sum
    sum_add = MAG_W'(sum_cur) + MAG_W'(m_cur);
    if (sum_add[SW] != sum_add[SW-1]) begin
      sum_sat = sum_add[SW] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_add[SW-1:0];
    end

    pp_sum = {1'b0, ev_r} + (VAR_W+1)'(process_noise);
    pp_sat = pp_sum[VAR_W] ? {VAR_W{1'b1}} : pp_sum[VAR_W-1:0];

    // one restoring division step
    trial     = {rem_r, shin_r[K_W-1]};
    trial_ge  = trial >= {1'b0, den_r};
    trial_sub = trial - {1'b0, den_r};

    d_mag   = MAG_W'(sum_cur) - MAG_W'(est_cur);
    mag_val = d_mag[MAG_W-1] ? (~d_mag + 1'b1) : d_mag;

    mag_pad = PAD_W'(mag_r);
    for (int i = 0; i < NCHUNK; i++) begin
      chunk_arr[i] = mag_pad[i*CHUNK_W +: CHUNK_W];
    end
    chunk = chunk_arr[ctl.cnt[CIDX_W-1:0]];

    if (ctl.op == OP_VAR_MUL) begin
      mul_a = pp_r;
      mul_b = K_ONE - k_r;
    end else begin
      mul_a = MUL_A_W'(chunk);
      mul_b = k_r;
    end

    step     = acc_r[VAR_FRAC +: MAG_W];
    move_val = up_r ? (MAG_W'(est_cur) + step) : (MAG_W'(est_cur) - step);

    d_out = DIFF_W'(est_cur) - DIFF_W'(sum_cur);

    // corrected = motion + (estimate - sum), clamped to 32 bits
    v_cor = COR_W'(m_cur) + COR_W'($signed(diff_r[COR_W-2:0]));
    if (diff_r > D_LIM) begin
      v_sat = OUT_MAX;
    end else if (diff_r < -D_LIM) begin
      v_sat = OUT_MIN;
    end else if (v_cor > V_MAX) begin
      v_sat = OUT_MAX;
    end else if (v_cor < V_MIN) begin
      v_sat = OUT_MIN;
    end else begin
      v_sat = v_cor[MOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      ev_r    <= VAR_ONE;
      for (int i = 0; i < 3; i++) begin
        held_r[i] <= '0;
        sum_r[i]  <= '0;
        est_r[i]  <= '0;
      end
    end else if (ld) begin
      if (in_restart) begin
        first_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= '0;
        end
      end
      if (in_motion_valid) begin
        held_r[AX_X]   <= in_shift_x;
        held_r[AX_Y]   <= in_shift_y;
        held_r[AX_ROT] <= in_rotation;
      end
    end else if (ctl.en) begin
      case (ctl.op)
        OP_SUM:     sum_r[ctl.axis] <= sum_sat;
        OP_MOVE:    est_r[ctl.axis] <= move_val[SW-1:0];
        OP_VAR_SET: ev_r <= prod_r[VAR_FRAC +: VAR_W];
        OP_INIT: begin
          first_r <= 1'b0;
          ev_r    <= VAR_ONE;
          for (int i = 0; i < 3; i++) begin
            est_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      case (ctl.op)
        OP_PP: pp_r <= pp_sat;
        OP_DIV_INIT: begin
          den_r  <= {1'b0, pp_r} + (VAR_W+1)'(measurement_noise);
          rem_r  <= (VAR_W+1)'(pp_r[VAR_W-1:1]);
          shin_r <= {pp_r[0], {VAR_FRAC{1'b0}}};
          q_r    <= '0;
        end
        OP_DIV_STEP: begin
          rem_r  <= trial_ge ? trial_sub[VAR_W:0] : trial[VAR_W:0];
          q_r    <= {q_r[K_W-2:0], trial_ge};
          shin_r <= {shin_r[K_W-2:0], 1'b0};
        end
        // a zero denominator leaves all quotient bits set: clamp gives gain one
        OP_K_SET: k_r <= (q_r > K_ONE) ? K_ONE : q_r;
        OP_MAG: begin
          up_r  <= !d_mag[MAG_W-1];
          mag_r <= mag_val;
          acc_r <= '0;
        end
        OP_MUL_CHUNK, OP_VAR_MUL: prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
        OP_ACC:  acc_r <= {acc_r[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(prod_r);
        OP_DIFF: diff_r <= d_out;
        OP_CORR: res_r[ctl.axis] <= v_sat;
        default: ;
      endcase
    end
  end

  assign first_frame = first_r;
  assign res_x       = res_r[AX_X];
  assign res_y       = res_r[AX_Y];
  assign res_rot     = res_r[AX_ROT];

endmodule
`default_nettype wire

// File: rtl/core/kalman_motion_smoother.sv
// Top level of the Kalman motion smoother: handshakes, registers and program sequencer.
//
// Usage:
//   Input channel (in_valid / in_stall): one frame's motion, a motion_valid flag that
//   reuses the last valid motion when clear, and a restart flag that clears the
//   trajectory sums and makes this frame the first one.
//   Output channel (out_valid / out_stall): corrected x, y and rotation, Q16.16.
//   Configuration: cfg_wr_en with cfg_index 0 (process noise) or 1 (measurement
//   noise), Q4.24 data; write only while no frame is in flight.
// Timing:
//   A frame runs through a microprogram of 46 + 6 * N steps, one step a cycle but for
//   the last, which waits while the output is stalled, with N = ceil((SUM_WIDTH + 1) / 24)
//   pieces per shared 32x25 multiply. The 25-step gain division and the three piecewise
//   estimate updates set that length. A first frame skips the filter and takes 11 steps.
//   The result shows on the cycle after the last step; the next frame can be taken in
//   that same cycle, so a new frame is taken only once the last one is through.
// Reset and stall:
//   Reset clears the sums and estimates, sets the variance to one and marks the
//   next frame as the first. in_stall is high while a frame is in work. When the
//   receiver stalls, the result register holds and the program waits on its last
//   step until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module kalman_motion_smoother #(
  parameter int SUM_WIDTH = kms_pkg::SUM_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic signed [kms_pkg::MOT_W-1:0]  in_shift_x,
  input  wire logic signed [kms_pkg::MOT_W-1:0]  in_shift_y,
  input  wire logic signed [kms_pkg::MOT_W-1:0]  in_rotation,
  input  wire                                    in_motion_valid,
  input  wire                                    in_restart,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [kms_pkg::MOT_W-1:0]       out_corrected_x,
  output logic signed [kms_pkg::MOT_W-1:0]       out_corrected_y,
  output logic signed [kms_pkg::MOT_W-1:0]       out_corrected_rotation,
  input  wire                                    cfg_wr_en,
  input  wire logic [kms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kms_pkg::NOISE_W-1:0]       cfg_data
);
  import kms_pkg::*;

  localparam int NCHUNK = nchunk(SUM_WIDTH);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } seq_state_t;

  seq_state_t              state_r, state_nxt;
  logic [STEP_W-1:0]       pc_r, pc_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [MOT_W-1:0] out_x_r, out_y_r, out_rot_r;
  logic [NOISE_W-1:0]      process_noise_r, measurement_noise_r;

  uword_t                  uw;
  dp_ctl_t                 dp_ctl;
  logic                    ld;
  logic                    done_go;
  logic                    first_frame;
  logic signed [MOT_W-1:0] res_x, res_y, res_rot;

  assign uw       = ucode(pc_r);
  assign ld       = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    dp_ctl.en   = (state_r == S_RUN);
    dp_ctl.op   = uw.op;
    dp_ctl.axis = uw.axis;
    dp_ctl.cnt  = cnt_r;
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    done_go       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RUN;
          pc_nxt    = PC_START;
        end
      end
      S_RUN: begin
        if (uw.op == OP_DIV_INIT) begin
          cnt_nxt = CNT_W'(DIV_STEPS - 1);
        end else if (uw.op == OP_MAG) begin
          cnt_nxt = CNT_W'(NCHUNK - 1);
        end
        case (uw.br)
          BR_NEXT:  pc_nxt = pc_r + 1'b1;
          BR_FIRST: pc_nxt = first_frame ? uw.target : pc_r + 1'b1;
          BR_LOOP: begin
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
              pc_nxt  = uw.target;
            end else begin
              pc_nxt = pc_r + 1'b1;
            end
          end
          BR_JUMP:  pc_nxt = uw.target;
          BR_END: begin
            // hold on the last step until the output register is free
            if (!out_valid_nxt) begin
              done_go       = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
              pc_nxt        = PC_START;
            end
          end
          default:  pc_nxt = PC_START;
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= PC_START;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (done_go) begin
        out_x_r   <= res_x;
        out_y_r   <= res_y;
        out_rot_r <= res_rot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r     <= PROCESS_NOISE_RST;
      measurement_noise_r <= MEAS_NOISE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise_r     <= cfg_data;
        REG_MEAS_NOISE:    measurement_noise_r <= cfg_data;
        default: ;
      endcase
    end
  end

  kms_datapath #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ld                (ld),
    .in_shift_x        (in_shift_x),
    .in_shift_y        (in_shift_y),
    .in_rotation       (in_rotation),
    .in_motion_valid   (in_motion_valid),
    .in_restart        (in_restart),
    .process_noise     (process_noise_r),
    .measurement_noise (measurement_noise_r),
    .ctl               (dp_ctl),
    .first_frame       (first_frame),
    .res_x             (res_x),
    .res_y             (res_y),
    .res_rot           (res_rot)
  );

  assign out_valid              = out_valid_r;
  assign out_corrected_x        = out_x_r;
  assign out_corrected_y        = out_y_r;
  assign out_corrected_rotation = out_rot_r;

endmodule
`default_nettype wire

// File: test/kalman_motion_smoother_test.sv
// Self-checking testbench for the Kalman motion smoother: directed frames, then random tracks.
`timescale 1ns / 1ps
module kalman_motion_smoother_test;

  localparam int     SUM_W    = kms_pkg::SUM_WIDTH_DEF;
  localparam int     MW       = kms_pkg::MOT_W;
  localparam int     NW       = kms_pkg::NOISE_W;
  localparam int     FR       = kms_pkg::VAR_FRAC;
  localparam longint TRAJ_HI  = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
  localparam longint TRAJ_LO  = -TRAJ_HI - 64'sd1;
  localparam longint MOT_HI   = 64'sd2147483647;
  localparam longint MOT_LO   = -64'sd2147483648;
  localparam logic [63:0] GAIN_ONE = 64'd1 << FR;
  localparam logic [MW-1:0] M_MAX = 32'h7FFF_FFFF;
  localparam logic [MW-1:0] M_MIN = 32'h8000_0000;
  localparam logic [NW-1:0] NOISE_MAX = {NW{1'b1}};
  localparam int     PHASES   = 10;
  localparam int     PHASE_FRAMES = 130;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] rot;
    logic                 motion_valid;
    logic                 restart;
  } frame_t;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] rot;
  } corr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  wire                   in_stall;
  logic signed [MW-1:0]  in_shift_x = '0;
  logic signed [MW-1:0]  in_shift_y = '0;
  logic signed [MW-1:0]  in_rotation = '0;
  logic                  in_motion_valid = 1'b0;
  logic                  in_restart = 1'b0;
  wire                   out_valid;
  logic                  out_stall = 1'b0;
  wire signed [MW-1:0]   out_corrected_x;
  wire signed [MW-1:0]   out_corrected_y;
  wire signed [MW-1:0]   out_corrected_rotation;
  logic                  cfg_wr_en = 1'b0;
  logic [kms_pkg::CFG_IDX_W-1:0] cfg_index = kms_pkg::REG_PROCESS_NOISE;
  logic [NW-1:0]         cfg_data = '0;

  kalman_motion_smoother #(
    .SUM_WIDTH(SUM_W)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_shift_x             (in_shift_x),
    .in_shift_y             (in_shift_y),
    .in_rotation            (in_rotation),
    .in_motion_valid        (in_motion_valid),
    .in_restart             (in_restart),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_corrected_x        (out_corrected_x),
    .out_corrected_y        (out_corrected_y),
    .out_corrected_rotation (out_corrected_rotation),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // smoother state as the testbench sees it
  logic                 first_pending = 1'b1;
  longint               traj_x = 0, traj_y = 0, traj_rot = 0;
  longint               smooth_x = 0, smooth_y = 0, smooth_rot = 0;
  logic [31:0]          err_var = kms_pkg::VAR_ONE;
  logic signed [MW-1:0] held_x = '0, held_y = '0, held_rot = '0;
  logic [NW-1:0]        proc_noise = kms_pkg::PROCESS_NOISE_RST;
  logic [NW-1:0]        meas_noise = kms_pkg::MEAS_NOISE_RST;

  frame_t frame_q[$];
  corr_t  corrected_q[$];
  int     frames_left = 0;
  int     frames_done = 0;
  int     results_seen = 0;
  int     mismatches = 0;
  int     settings_used = 1;

  bit     in_accepted = 1'b0;
  int     in_gap = 0;
  int     in_idle_max = 14;
  int     out_wait = 0;
  int     out_idle_max = 14;

  function automatic longint traj_add(longint s, longint m);
    if (m > 0 && s > TRAJ_HI - m) return TRAJ_HI;
    if (m < 0 && s < TRAJ_LO - m) return TRAJ_LO;
    return s + m;
  endfunction

  // move the estimate toward the sum by gain k, step truncated toward zero
  function automatic longint track_step(longint est, longint z, logic [63:0] k);
    logic        up;
    logic [63:0] mag, step, r;
    up = z >= est;
    mag = up ? z - est : est - z;
    step = (mag >> FR) * k + (((mag & (GAIN_ONE - 64'd1)) * k) >> FR);
    r = up ? est + step : est - step;
    return $signed(r);
  endfunction

  function automatic logic [MW-1:0] correct_axis(longint m, longint est, longint sum);
    logic        up;
    logic [63:0] mag;
    longint      v;
    up = est >= sum;
    mag = up ? est - sum : sum - est;
    if (mag > (64'd1 << 34)) begin
      v = up ? MOT_HI : MOT_LO;
    end else begin
      v = up ? m + $signed(mag) : m - $signed(mag);
      if (v > MOT_HI) v = MOT_HI;
      if (v < MOT_LO) v = MOT_LO;
    end
    return v[MW-1:0];
  endfunction

  function automatic corr_t smooth_frame(frame_t f);
    corr_t       c;
    longint      mx, my, mr;
    logic [63:0] pp, den, k;
    if (f.restart) begin
      traj_x = 0;
      traj_y = 0;
      traj_rot = 0;
      first_pending = 1'b1;
    end
    if (f.motion_valid) begin
      held_x = f.x;
      held_y = f.y;
      held_rot = f.rot;
    end
    mx = held_x;
    my = held_y;
    mr = held_rot;
    traj_x = traj_add(traj_x, mx);
    traj_y = traj_add(traj_y, my);
    traj_rot = traj_add(traj_rot, mr);
    if (first_pending) begin
      smooth_x = 0;
      smooth_y = 0;
      smooth_rot = 0;
      err_var = kms_pkg::VAR_ONE;
      first_pending = 1'b0;
    end else begin
      pp = 64'(err_var) + 64'(proc_noise);
      if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
      den = pp + 64'(meas_noise);
      k = (den == 64'd0) ? GAIN_ONE : (pp << FR) / den;
      if (k > GAIN_ONE) k = GAIN_ONE;
      smooth_x = track_step(smooth_x, traj_x, k);
      smooth_y = track_step(smooth_y, traj_y, k);
      smooth_rot = track_step(smooth_rot, traj_rot, k);
      err_var = 32'(((GAIN_ONE - k) * pp) >> FR);
    end
    c.x = correct_axis(mx, smooth_x, traj_x);
    c.y = correct_axis(my, smooth_y, traj_y);
    c.rot = correct_axis(mr, smooth_rot, traj_rot);
    return c;
  endfunction

  // input driver: hold a stalled frame, idle for the drawn gap, then present the next
  always @(negedge clk) begin : feed
    frame_t f;
    if (rst_n && !(in_valid && !in_accepted)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (frame_q.size() != 0) begin
        f = frame_q.pop_front();
        in_valid <= 1'b1;
        in_shift_x <= f.x;
        in_shift_y <= f.y;
        in_rotation <= f.rot;
        in_motion_valid <= f.motion_valid;
        in_restart <= f.restart;
        in_gap = (in_idle_max != 0) ? $urandom_range(0, in_idle_max) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall a waiting result for the drawn count, toggle while idle
  always @(negedge clk) begin
    if (out_wait != 0 && out_valid === 1'b1) begin
      out_stall <= 1'b1;
      out_wait = out_wait - 1;
    end else if (out_valid === 1'b0 && out_idle_max != 0) begin
      out_stall <= 1'($urandom_range(0, 1));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : watch
    frame_t f;
    corr_t  got, want;
    if (rst_n) begin
      in_accepted = in_valid && !in_stall;
      if (in_accepted) begin
        f.x = in_shift_x;
        f.y = in_shift_y;
        f.rot = in_rotation;
        f.motion_valid = in_motion_valid;
        f.restart = in_restart;
        corrected_q.insert(corrected_q.size(), smooth_frame(f));
        frames_left--;
        frames_done++;
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        out_wait = (out_idle_max != 0) ? $urandom_range(0, out_idle_max) : 0;
        got.x = out_corrected_x;
        got.y = out_corrected_y;
        got.rot = out_corrected_rotation;
        if (corrected_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result transfer %0d: %0d %0d %0d", results_seen,
                     got.x, got.y, got.rot);
          mismatches++;
        end else begin
          want = corrected_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d", results_seen,
                       want.x, want.y, want.rot, got.x, got.y, got.rot);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic add_frame(input logic [MW-1:0] x, input logic [MW-1:0] y,
                           input logic [MW-1:0] r, input logic mv, input logic rs);
    frame_t f;
    f.x = x;
    f.y = y;
    f.rot = r;
    f.motion_valid = mv;
    f.restart = rs;
    frame_q.insert(frame_q.size(), f);
    frames_left++;
  endtask

  function automatic logic [MW-1:0] drift_value(int kind);
    logic [MW-1:0] v;
    case (kind)
      0: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      1: v = $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: v = M_MAX;
          1: v = M_MIN;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      default: v = $urandom_range(0, 1) ? 32'h7000_0000 + $urandom_range(0, 32'h0FFF_FFFF)
                                        : 32'h8000_0000 + $urandom_range(0, 32'h0FFF_FFFF);
    endcase
    return v;
  endfunction

  // camera tracks: mostly a restart, then a run of frames around a steady drift
  task automatic queue_tracks(input int count);
    int            left, kind;
    logic [MW-1:0] dx, dy, dr;
    logic          rs;
    left = 0;
    @(posedge clk);
    repeat (count) begin
      if (left == 0) begin
        left = $urandom_range(2, 40);
        kind = $urandom_range(0, 3);
        dx = drift_value(kind);
        dy = drift_value(kind);
        dr = drift_value(kind);
        rs = ($urandom_range(0, 3) != 0);
      end else begin
        rs = ($urandom_range(0, 63) == 0);
      end
      left--;
      if ($urandom_range(0, 9) == 0)
        add_frame($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), rs);
      else
        add_frame(dx + $urandom_range(0, 2047) - 1024, dy + $urandom_range(0, 2047) - 1024,
                  dr + $urandom_range(0, 2047) - 1024, ($urandom_range(0, 7) != 0), rs);
    end
  endtask

  task automatic drain();
    while (frames_left != 0 || corrected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_noise(input logic [kms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [NW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == kms_pkg::REG_PROCESS_NOISE) proc_noise = value;
    else meas_noise = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    logic [NW-1:0] pn, mn;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, held motion reuse, restarts, output saturation
    @(posedge clk);
    repeat (5) add_frame(M_MAX, M_MIN, '0, 1'b1, 1'b0);
    add_frame(32'd1, '1, '0, 1'b0, 1'b0);
    add_frame('0, '0, '0, 1'b0, 1'b1);
    add_frame('0, '0, '0, 1'b0, 1'b0);
    add_frame('1, 32'd1, M_MIN, 1'b1, 1'b1);
    repeat (4) add_frame(M_MIN, M_MAX, M_MAX, 1'b1, 1'b0);
    repeat (3) add_frame('0, '0, '0, 1'b1, 1'b0);
    add_frame(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 1'b1, 1'b0);
    add_frame(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 1'b1, 1'b0);
    add_frame(M_MAX, M_MAX, M_MAX, 1'b0, 1'b0);
    add_frame(M_MIN, M_MIN, M_MIN, 1'b1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin pn = '0; mn = 1; end
        1: begin pn = NOISE_MAX; mn = NOISE_MAX; end
        2: begin pn = kms_pkg::PROCESS_NOISE_RST; mn = kms_pkg::MEAS_NOISE_RST; end
        3: begin pn = NOISE_MAX; mn = 1; end
        4: begin pn = '0; mn = NOISE_MAX; end
        default: begin
          pn = NW'($urandom_range(0, NOISE_MAX) >> $urandom_range(0, 24));
          mn = NW'($urandom_range(1, NOISE_MAX) >> $urandom_range(0, 24));
          if (mn == '0) mn = 1;
        end
      endcase
      write_noise(kms_pkg::REG_PROCESS_NOISE, pn);
      write_noise(kms_pkg::REG_MEAS_NOISE, mn);
      settings_used++;
      in_idle_max = (ph % 3 == 2) ? 0 : 14;
      out_idle_max = (ph % 4 == 2) ? 0 : 14;
      queue_tracks(PHASE_FRAMES);
    end

    drain();
    repeat (100) @(negedge clk);
    $display("Covered %0d frames under %0d noise settings; %0d corrected results checked.",
             frames_done, settings_used, results_seen);
    $display("Mismatched or unexpected results: %0d, results still owed: %0d.",
             mismatches, corrected_q.size());
    if (mismatches == 0 && corrected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
